/* hdl/cel_pkg.sv */
// shared types and constants for the cell edge unit normal pipeline
// no dependencies
package cel_pkg;

    localparam int NUM_EDGES  = 4;
    localparam int OUT_WIDTH  = 16;
    // normalized edge magnitudes carry this many bits
    localparam int SCALE_BITS = 30;
    localparam int SQRT_STEPS = 31;
    // width of the square root and divider remainders
    localparam int REM_WIDTH  = 62;

    typedef struct packed {
        logic [NUM_EDGES-1:0] neg_x;
        logic [NUM_EDGES-1:0] neg_y;
        logic [NUM_EDGES-1:0] kill;
        logic                 degenerate;
    } edge_ctl_t;

endpackage

/* hdl/cel_front.sv */
// front end: corner differences, exact area signs, edge magnitudes, leading zero counts
// depends on cel_pkg
module cel_front
    import cel_pkg::*;
#(
    parameter int COORD_WIDTH = 24
)
(
    input  logic                                              clk,
    input  logic                                              en,
    input  logic                                              is_quad,
    input  logic signed [COORD_WIDTH-1:0]                     x0,
    input  logic signed [COORD_WIDTH-1:0]                     y0,
    input  logic signed [COORD_WIDTH-1:0]                     x1,
    input  logic signed [COORD_WIDTH-1:0]                     y1,
    input  logic signed [COORD_WIDTH-1:0]                     x2,
    input  logic signed [COORD_WIDTH-1:0]                     y2,
    input  logic signed [COORD_WIDTH-1:0]                     x3,
    input  logic signed [COORD_WIDTH-1:0]                     y3,
    output logic [NUM_EDGES-1:0][COORD_WIDTH:0]               ma,
    output logic [NUM_EDGES-1:0][COORD_WIDTH:0]               mb,
    output logic [NUM_EDGES-1:0][$clog2(COORD_WIDTH+2)-1:0]   lz,
    output edge_ctl_t                                         ctl
);

    localparam int DW  = COORD_WIDTH + 1;
    localparam int PW  = 2 * DW;
    localparam int LZW = $clog2(COORD_WIDTH + 2);

    // stage 1: differences
    logic signed [DW-1:0] u1_reg, v1_reg, u2_reg, v2_reg, u3_reg, v3_reg;
    logic signed [DW-1:0] ex_reg [NUM_EDGES];
    logic signed [DW-1:0] ey_reg [NUM_EDGES];
    logic                 quad1_reg;

    // stage 2: products and magnitudes
    logic signed [PW-1:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic [DW-1:0]        ma2_reg [NUM_EDGES];
    logic [DW-1:0]        mb2_reg [NUM_EDGES];
    logic [NUM_EDGES-1:0] dxn2_reg, dyn2_reg;
    logic                 quad2_reg;

    // stage 3: outputs
    logic [NUM_EDGES-1:0][DW-1:0]  ma_reg, mb_reg;
    logic [NUM_EDGES-1:0][LZW-1:0] lz_reg;
    edge_ctl_t                     ctl_reg;

    logic signed [DW-1:0] dx_next [NUM_EDGES];
    logic signed [DW-1:0] dy_next [NUM_EDGES];

    always_comb
    begin
        dx_next[0] = DW'(x1) - DW'(x0);
        dy_next[0] = DW'(y1) - DW'(y0);
        dx_next[1] = DW'(x2) - DW'(x1);
        dy_next[1] = DW'(y2) - DW'(y1);
        dx_next[2] = is_quad ? DW'(x3) - DW'(x2) : DW'(x0) - DW'(x2);
        dy_next[2] = is_quad ? DW'(y3) - DW'(y2) : DW'(y0) - DW'(y2);
        dx_next[3] = DW'(x0) - DW'(x3);
        dy_next[3] = DW'(y0) - DW'(y3);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u1_reg    <= DW'(x1) - DW'(x0);
            v1_reg    <= DW'(y1) - DW'(y0);
            u2_reg    <= DW'(x2) - DW'(x0);
            v2_reg    <= DW'(y2) - DW'(y0);
            u3_reg    <= DW'(x3) - DW'(x0);
            v3_reg    <= DW'(y3) - DW'(y0);
            quad1_reg <= is_quad;
            for (int k = 0; k < NUM_EDGES; k++)
            begin
                ex_reg[k] <= dx_next[k];
                ey_reg[k] <= dy_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg    <= PW'(u1_reg) * PW'(v2_reg);
            pb_reg    <= PW'(v1_reg) * PW'(u2_reg);
            pc_reg    <= PW'(u2_reg) * PW'(v3_reg);
            pd_reg    <= PW'(v2_reg) * PW'(u3_reg);
            quad2_reg <= quad1_reg;
            for (int k = 0; k < NUM_EDGES; k++)
            begin
                // normal x comes from dy, normal y from dx
                ma2_reg[k]  <= ey_reg[k][DW-1] ? DW'(-ey_reg[k]) : DW'(ey_reg[k]);
                mb2_reg[k]  <= ex_reg[k][DW-1] ? DW'(-ex_reg[k]) : DW'(ex_reg[k]);
                dxn2_reg[k] <= ex_reg[k][DW-1];
                dyn2_reg[k] <= ey_reg[k][DW-1];
            end
        end
    end

    logic signed [PW:0]    area_a, area_b;
    logic                  sa_neg, sb_neg, degen;
    logic [NUM_EDGES-1:0]  s_neg;
    logic [LZW-1:0]        lz_next [NUM_EDGES];
    logic [DW-1:0]         m_or;

    always_comb
    begin
        area_a = {pa_reg[PW-1], pa_reg} - {pb_reg[PW-1], pb_reg};
        area_b = {pc_reg[PW-1], pc_reg} - {pd_reg[PW-1], pd_reg};
        sa_neg = area_a[PW];
        sb_neg = area_b[PW];
        degen  = (area_a == '0) || (quad2_reg && (area_b == '0));
        s_neg[0] = sa_neg;
        s_neg[1] = sa_neg;
        s_neg[2] = quad2_reg ? sb_neg : sa_neg;
        s_neg[3] = sb_neg;
        for (int k = 0; k < NUM_EDGES; k++)
        begin
            m_or       = ma2_reg[k] | mb2_reg[k];
            lz_next[k] = LZW'(DW);
            for (int b = 0; b < DW; b++)
            begin
                if (m_or[b])
                    lz_next[k] = LZW'(DW - 1 - b);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NUM_EDGES; k++)
            begin
                ma_reg[k]           <= ma2_reg[k];
                mb_reg[k]           <= mb2_reg[k];
                lz_reg[k]           <= lz_next[k];
                ctl_reg.neg_x[k]    <= dyn2_reg[k] ^ s_neg[k];
                ctl_reg.neg_y[k]    <= ~(dxn2_reg[k] ^ s_neg[k]);
                ctl_reg.kill[k]     <= degen || ((k == NUM_EDGES - 1) && !quad2_reg);
            end
            ctl_reg.degenerate <= degen;
        end
    end

    assign ma  = ma_reg;
    assign mb  = mb_reg;
    assign lz  = lz_reg;
    assign ctl = ctl_reg;

endmodule

/* hdl/cel_lane.sv */
// one edge lane: normalize, square and sum, pipelined square root, two pipelined dividers
// depends on cel_pkg
module cel_lane
    import cel_pkg::*;
#(
    parameter int COORD_WIDTH      = 24,
    parameter int NORMAL_FRAC_BITS = 14
)
(
    input  logic                               clk,
    input  logic                               en,
    input  logic [COORD_WIDTH:0]               ma,
    input  logic [COORD_WIDTH:0]               mb,
    input  logic [$clog2(COORD_WIDTH+2)-1:0]   lz,
    output logic [NORMAL_FRAC_BITS:0]          qa,
    output logic [NORMAL_FRAC_BITS:0]          qb
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int EW = DW + SCALE_BITS;
    localparam int F  = NORMAL_FRAC_BITS;
    localparam int QW = F + 1;
    localparam int RW = SQRT_STEPS;

    logic [EW-1:0]             ea, eb;
    logic [SCALE_BITS-1:0]     a1_reg, b1_reg, a2_reg, b2_reg;
    logic [2*SCALE_BITS-1:0]   aa2_reg, bb2_reg;

    // top set bit lands at the head of the extended word
    assign ea = {ma, {SCALE_BITS{1'b0}}} << lz;
    assign eb = {mb, {SCALE_BITS{1'b0}}} << lz;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg  <= ea[EW-1 -: SCALE_BITS];
            b1_reg  <= eb[EW-1 -: SCALE_BITS];
            aa2_reg <= a1_reg * a1_reg;
            bb2_reg <= b1_reg * b1_reg;
            a2_reg  <= a1_reg;
            b2_reg  <= b1_reg;
        end
    end

    // square root, one result bit per stage
    logic [REM_WIDTH-1:0]  rem_reg [SQRT_STEPS+1];
    logic [RW-1:0]         res_reg [SQRT_STEPS+1];
    logic [SCALE_BITS-1:0] ac_reg  [SQRT_STEPS+1];
    logic [SCALE_BITS-1:0] bc_reg  [SQRT_STEPS+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= REM_WIDTH'(aa2_reg) + REM_WIDTH'(bb2_reg);
            res_reg[0] <= '0;
            ac_reg[0]  <= a2_reg;
            bc_reg[0]  <= b2_reg;
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        localparam int I = SQRT_STEPS - 1 - k;
        logic [REM_WIDTH:0] trial;
        logic               fits;

        assign trial = ((REM_WIDTH+1)'(res_reg[k]) << (I + 1))
                     + ((REM_WIDTH+1)'(1) << (2 * I));
        assign fits  = trial <= {1'b0, rem_reg[k]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= fits ? rem_reg[k] - trial[REM_WIDTH-1:0] : rem_reg[k];
                res_reg[k+1] <= fits ? (res_reg[k] | (RW'(1) << I)) : res_reg[k];
                ac_reg[k+1]  <= ac_reg[k];
                bc_reg[k+1]  <= bc_reg[k];
            end
        end
    end

    // rounded division, one quotient bit per stage
    logic [REM_WIDTH-1:0] ra_reg [QW+1];
    logic [REM_WIDTH-1:0] rb_reg [QW+1];
    logic [RW-1:0]        r_reg  [QW+1];
    logic [QW-1:0]        qa_reg [QW+1];
    logic [QW-1:0]        qb_reg [QW+1];
    logic [RW-1:0]        root;

    assign root = res_reg[SQRT_STEPS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ra_reg[0] <= (REM_WIDTH'(ac_reg[SQRT_STEPS]) << F) + REM_WIDTH'(root >> 1);
            rb_reg[0] <= (REM_WIDTH'(bc_reg[SQRT_STEPS]) << F) + REM_WIDTH'(root >> 1);
            r_reg[0]  <= root;
            qa_reg[0] <= '0;
            qb_reg[0] <= '0;
        end
    end

    for (genvar t = 0; t < QW; t++)
    begin : g_div
        localparam int J = QW - 1 - t;
        logic [REM_WIDTH-1:0] dvs;
        logic                 ga, gb;

        assign dvs = REM_WIDTH'(r_reg[t]) << J;
        assign ga  = ra_reg[t] >= dvs;
        assign gb  = rb_reg[t] >= dvs;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ra_reg[t+1] <= ga ? ra_reg[t] - dvs : ra_reg[t];
                rb_reg[t+1] <= gb ? rb_reg[t] - dvs : rb_reg[t];
                qa_reg[t+1] <= ga ? (qa_reg[t] | (QW'(1) << J)) : qa_reg[t];
                qb_reg[t+1] <= gb ? (qb_reg[t] | (QW'(1) << J)) : qb_reg[t];
                r_reg[t+1]  <= r_reg[t];
            end
        end
    end

    assign qa = qa_reg[QW];
    assign qb = qb_reg[QW];

endmodule

/* hdl/cell_edge_unit_normals.sv */
// top level of the cell edge unit normal pipeline
// depends on cel_pkg, cel_front, cel_lane
//
// usage:
//   input channel: in_valid / in_ready with is_quad and corners x0..y3,
//   one cell per beat. output channel: out_valid / out_ready with the
//   eight normal components and the degenerate flag, one result per cell.
// pipeline: from an accepted input beat to out_valid, 3 front stages for
//   differences, area signs and leading zero counts, 3 normalize / square
//   stages, 31 square root stages at one root bit each, 1 rounding stage,
//   NORMAL_FRAC_BITS + 1 divider stages at one quotient bit each, and the
//   output register.
// throughput: one cell per cycle while the receiver takes results.
// stall: when out_valid is high and out_ready low the whole pipeline holds,
//   in_ready drops in that same cycle, and nothing is lost or repeated.
// reset: all valid bits clear, so out_valid is low until a cell has gone
//   through; payload registers are not reset.
module cell_edge_unit_normals
    import cel_pkg::*;
#(
    parameter int COORD_WIDTH      = 24,
    parameter int NORMAL_FRAC_BITS = 14
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          is_quad,
    input  logic signed [COORD_WIDTH-1:0] x0,
    input  logic signed [COORD_WIDTH-1:0] y0,
    input  logic signed [COORD_WIDTH-1:0] x1,
    input  logic signed [COORD_WIDTH-1:0] y1,
    input  logic signed [COORD_WIDTH-1:0] x2,
    input  logic signed [COORD_WIDTH-1:0] y2,
    input  logic signed [COORD_WIDTH-1:0] x3,
    input  logic signed [COORD_WIDTH-1:0] y3,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [OUT_WIDTH-1:0]   nx_edge0,
    output logic signed [OUT_WIDTH-1:0]   ny_edge0,
    output logic signed [OUT_WIDTH-1:0]   nx_edge1,
    output logic signed [OUT_WIDTH-1:0]   ny_edge1,
    output logic signed [OUT_WIDTH-1:0]   nx_edge2,
    output logic signed [OUT_WIDTH-1:0]   ny_edge2,
    output logic signed [OUT_WIDTH-1:0]   nx_edge3,
    output logic signed [OUT_WIDTH-1:0]   ny_edge3,
    output logic                          degenerate
);

    localparam int DW        = COORD_WIDTH + 1;
    localparam int LZW       = $clog2(COORD_WIDTH + 2);
    localparam int QW        = NORMAL_FRAC_BITS + 1;
    localparam int FRONT_LAT = 3;
    localparam int LANE_LAT  = 3 + SQRT_STEPS + 1 + QW;
    localparam int PIPE      = FRONT_LAT + LANE_LAT;

    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    logic [NUM_EDGES-1:0][DW-1:0]  ma, mb;
    logic [NUM_EDGES-1:0][LZW-1:0] lz;
    edge_ctl_t                     front_ctl;

    cel_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk     (clk),
        .en      (en),
        .is_quad (is_quad),
        .x0      (x0),
        .y0      (y0),
        .x1      (x1),
        .y1      (y1),
        .x2      (x2),
        .y2      (y2),
        .x3      (x3),
        .y3      (y3),
        .ma      (ma),
        .mb      (mb),
        .lz      (lz),
        .ctl     (front_ctl)
    );

    logic [QW-1:0] qa [NUM_EDGES];
    logic [QW-1:0] qb [NUM_EDGES];

    for (genvar k = 0; k < NUM_EDGES; k++)
    begin : g_lane
        cel_lane #(
            .COORD_WIDTH      (COORD_WIDTH),
            .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
        ) u_lane (
            .clk (clk),
            .en  (en),
            .ma  (ma[k]),
            .mb  (mb[k]),
            .lz  (lz[k]),
            .qa  (qa[k]),
            .qb  (qb[k])
        );
    end

    // valid bits and sign / mask control travel beside the lanes
    logic [PIPE-1:0] v_reg;
    edge_ctl_t       ctl_reg [LANE_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg         <= {v_reg[PIPE-2:0], in_valid};
            out_valid_reg <= v_reg[PIPE-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg[0] <= front_ctl;
            for (int j = 1; j < LANE_LAT; j++)
                ctl_reg[j] <= ctl_reg[j-1];
        end
    end

    edge_ctl_t                    c;
    logic signed [QW:0]           sx [NUM_EDGES];
    logic signed [QW:0]           sy [NUM_EDGES];
    logic [NUM_EDGES-1:0][OUT_WIDTH-1:0] nx_reg, ny_reg;
    logic                         degen_reg;

    always_comb
    begin
        c = ctl_reg[LANE_LAT-1];
        for (int k = 0; k < NUM_EDGES; k++)
        begin
            sx[k] = c.neg_x[k] ? -$signed({1'b0, qa[k]}) : $signed({1'b0, qa[k]});
            sy[k] = c.neg_y[k] ? -$signed({1'b0, qb[k]}) : $signed({1'b0, qb[k]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NUM_EDGES; k++)
            begin
                nx_reg[k] <= c.kill[k] ? '0 : OUT_WIDTH'(sx[k]);
                ny_reg[k] <= c.kill[k] ? '0 : OUT_WIDTH'(sy[k]);
            end
            degen_reg <= c.degenerate;
        end
    end

    assign out_valid  = out_valid_reg;
    assign nx_edge0   = nx_reg[0];
    assign ny_edge0   = ny_reg[0];
    assign nx_edge1   = nx_reg[1];
    assign ny_edge1   = ny_reg[1];
    assign nx_edge2   = nx_reg[2];
    assign ny_edge2   = ny_reg[2];
    assign nx_edge3   = nx_reg[3];
    assign ny_edge3   = ny_reg[3];
    assign degenerate = degen_reg;

endmodule

/* hdl/cel_checker.sv */
// port level checks for the cell edge unit normal pipeline, bound to the top level
// depends on cel_pkg and cell_edge_unit_normals
module cel_checker
    import cel_pkg::*;
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic signed [OUT_WIDTH-1:0] nx_edge0,
    input logic signed [OUT_WIDTH-1:0] ny_edge0,
    input logic signed [OUT_WIDTH-1:0] nx_edge1,
    input logic signed [OUT_WIDTH-1:0] ny_edge1,
    input logic signed [OUT_WIDTH-1:0] nx_edge2,
    input logic signed [OUT_WIDTH-1:0] ny_edge2,
    input logic signed [OUT_WIDTH-1:0] nx_edge3,
    input logic signed [OUT_WIDTH-1:0] ny_edge3,
    input logic                        degenerate
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(nx_edge0) && $stable(ny_edge0)
            && $stable(nx_edge3) && $stable(degenerate))
        else $error("stalled result beat changed");

    // the whole pipeline stalls only on a blocked output
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow the output stall");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> nx_edge0 == 0 && ny_edge0 == 0 && nx_edge1 == 0
            && ny_edge1 == 0 && nx_edge2 == 0 && ny_edge2 == 0 && nx_edge3 == 0
            && ny_edge3 == 0)
        else $error("degenerate cell with nonzero normals");

    // a proper cell has a nonzero first edge
    a_edge0_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !degenerate |-> nx_edge0 != 0 || ny_edge0 != 0)
        else $error("zero normal on a proper cell");

    a_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result beat out of reset");

endmodule

bind cell_edge_unit_normals cel_checker u_cel_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .nx_edge0   (nx_edge0),
    .ny_edge0   (ny_edge0),
    .nx_edge1   (nx_edge1),
    .ny_edge1   (ny_edge1),
    .nx_edge2   (nx_edge2),
    .ny_edge2   (ny_edge2),
    .nx_edge3   (nx_edge3),
    .ny_edge3   (ny_edge3),
    .degenerate (degenerate)
);

/* test/cell_edge_unit_normals_check.sv */
// checker for the cell edge unit normal block: watches both channels,
// predicts each result and compares it field by field; depends on cel_pkg
`timescale 1ns / 1ps

module cell_edge_unit_normals_check
    import cel_pkg::*;
#(
    parameter int COORD_WIDTH      = 24,
    parameter int NORMAL_FRAC_BITS = 14
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          is_quad,
    input  logic signed [COORD_WIDTH-1:0] x0,
    input  logic signed [COORD_WIDTH-1:0] y0,
    input  logic signed [COORD_WIDTH-1:0] x1,
    input  logic signed [COORD_WIDTH-1:0] y1,
    input  logic signed [COORD_WIDTH-1:0] x2,
    input  logic signed [COORD_WIDTH-1:0] y2,
    input  logic signed [COORD_WIDTH-1:0] x3,
    input  logic signed [COORD_WIDTH-1:0] y3,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic signed [OUT_WIDTH-1:0]   nx_edge0,
    input  logic signed [OUT_WIDTH-1:0]   ny_edge0,
    input  logic signed [OUT_WIDTH-1:0]   nx_edge1,
    input  logic signed [OUT_WIDTH-1:0]   ny_edge1,
    input  logic signed [OUT_WIDTH-1:0]   nx_edge2,
    input  logic signed [OUT_WIDTH-1:0]   ny_edge2,
    input  logic signed [OUT_WIDTH-1:0]   nx_edge3,
    input  logic signed [OUT_WIDTH-1:0]   ny_edge3,
    input  logic                          degenerate,
    output int                            errors,
    output int                            pending
);

    typedef struct packed {
        logic [2*NUM_EDGES-1:0][OUT_WIDTH-1:0] n;
        logic                                  degen;
    } normals_t;

    normals_t expected_normals[$];

    assign pending = expected_normals.size();

    // exact sign of ax*by - ay*bx
    function automatic int area_sign(longint ax, longint ay, longint bx, longint by);
        logic signed [127:0] c;
        c = 128'(ax) * 128'(by) - 128'(ay) * 128'(bx);
        if (c == 0)
            return 0;
        return c < 0 ? -1 : 1;
    endfunction

    function automatic void unit_normal(longint dx, longint dy, int s,
                                        output logic [OUT_WIDTH-1:0] nx,
                                        output logic [OUT_WIDTH-1:0] ny);
        logic [63:0] ma, mb, m, r, cand, qa, qb;
        int p;
        ma = dy < 0 ? -dy : dy;
        mb = dx < 0 ? -dx : dx;
        m = ma | mb;
        p = 0;
        while (p < 64 && (m >> p) != 0)
            p++;
        if (p > SCALE_BITS) begin
            ma = ma >> (p - SCALE_BITS);
            mb = mb >> (p - SCALE_BITS);
        end else begin
            ma = ma << (SCALE_BITS - p);
            mb = mb << (SCALE_BITS - p);
        end
        m = ma * ma + mb * mb;
        r = 0;
        for (int i = 30; i >= 0; i--) begin
            cand = r | (64'd1 << i);
            if (cand * cand <= m)
                r = cand;
        end
        if (r == 0) begin
            nx = '0;
            ny = '0;
            return;
        end
        qa = ((ma << NORMAL_FRAC_BITS) + (r >> 1)) / r;
        qb = ((mb << NORMAL_FRAC_BITS) + (r >> 1)) / r;
        nx = ((dy < 0) != (s < 0)) ? OUT_WIDTH'(-qa) : OUT_WIDTH'(qa);
        ny = ((dx < 0) == (s < 0)) ? OUT_WIDTH'(-qb) : OUT_WIDTH'(qb);
    endfunction

    function automatic normals_t predict_normals(logic q, longint cx[4], longint cy[4]);
        normals_t res;
        int sa, sb, cnt, nk, s;
        sb = 1;
        res = '0;
        sa = area_sign(cx[1] - cx[0], cy[1] - cy[0], cx[2] - cx[0], cy[2] - cy[0]);
        res.degen = (sa == 0);
        if (q) begin
            sb = area_sign(cx[2] - cx[0], cy[2] - cy[0], cx[3] - cx[0], cy[3] - cy[0]);
            if (sb == 0)
                res.degen = 1'b1;
        end
        if (!res.degen) begin
            cnt = q ? 4 : 3;
            for (int k = 0; k < cnt; k++) begin
                nk = (k + 1 == cnt) ? 0 : k + 1;
                s = (q && k >= 2) ? sb : sa;
                unit_normal(cx[nk] - cx[k], cy[nk] - cy[k], s, res.n[2*k], res.n[2*k+1]);
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        longint cx[4], cy[4];
        normals_t got, want;
        if (!rst_n) begin
            errors <= 0;
            expected_normals.delete();
        end else begin
            if (in_valid && in_ready) begin
                cx = '{x0, x1, x2, x3};
                cy = '{y0, y1, y2, y3};
                expected_normals = {expected_normals, predict_normals(is_quad, cx, cy)};
            end
            if (out_valid && out_ready) begin
                got.n = {ny_edge3, nx_edge3, ny_edge2, nx_edge2,
                         ny_edge1, nx_edge1, ny_edge0, nx_edge0};
                got.degen = degenerate;
                if (expected_normals.size() == 0) begin
                    if (errors < 10)
                        $display("unexpected result beat at %0t", $realtime);
                    errors <= errors + 1;
                end else begin
                    want = expected_normals.pop_front();
                    if (got !== want) begin
                        if (errors < 10) begin
                            $display("mismatch at %0t", $realtime);
                            for (int k = 0; k < 2 * NUM_EDGES; k++)
                                $display("  normal %0d: expected %0d got %0d", k,
                                         $signed(want.n[k]), $signed(got.n[k]));
                            $display("  degenerate: expected %0b got %0b",
                                     want.degen, got.degen);
                        end
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

/* test/cell_edge_unit_normals_test.sv */
// stimulus and verdict for the cell edge unit normal block
// depends on cel_pkg, cell_edge_unit_normals and cell_edge_unit_normals_check
`timescale 1ns / 1ps

module cell_edge_unit_normals_test;
    import cel_pkg::*;

    localparam int CW        = 24;
    localparam int NFB       = 14;
    localparam int LATENCY   = NFB + 40;
    localparam int IDLE_LIMIT = 5000;
    localparam longint CMAX  = (64'sd1 <<< (CW - 1)) - 1;
    localparam longint CMIN  = -(64'sd1 <<< (CW - 1));

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_ready;
    logic is_quad = 0;
    logic signed [CW-1:0] x0 = 0, y0 = 0, x1 = 0, y1 = 0, x2 = 0, y2 = 0, x3 = 0, y3 = 0;
    logic out_valid;
    logic out_ready = 0;
    logic signed [OUT_WIDTH-1:0] nx_edge0, ny_edge0, nx_edge1, ny_edge1;
    logic signed [OUT_WIDTH-1:0] nx_edge2, ny_edge2, nx_edge3, ny_edge3;
    logic degenerate;
    int errors, pending;
    int send_idle_pct = 0, recv_stall_pct = 0;
    int quiet_cycles = 0;

    always #5 clk = ~clk;

    cell_edge_unit_normals #(.COORD_WIDTH(CW), .NORMAL_FRAC_BITS(NFB)) dut (.*);
    cell_edge_unit_normals_check #(.COORD_WIDTH(CW), .NORMAL_FRAC_BITS(NFB)) checker_i (.*);

    // receiver stalls at random
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // watchdog on cycles with no beat on either channel
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic longint rand_coord(int mode);
        case (mode)
            0: return $signed(CW'($urandom));
            1: return $signed(CW'($urandom_range(63))) - 32;
            2: return $urandom_range(1) ? CMAX - $urandom_range(15) : CMIN + $urandom_range(15);
            default: return $signed(CW'($urandom)) >>> $urandom_range(CW - 1);
        endcase
    endfunction

    task automatic send_cell(logic q, longint c[8]);
        int gap;
        gap = 0;
        // valid only drops when an idle gap is taken
        while ($urandom_range(99) < send_idle_pct && gap < 20) begin
            in_valid <= 1'b0;
            @(posedge clk);
            gap++;
        end
        in_valid <= 1'b1;
        is_quad <= q;
        {x0, y0, x1, y1} <= {CW'(c[0]), CW'(c[1]), CW'(c[2]), CW'(c[3])};
        {x2, y2, x3, y3} <= {CW'(c[4]), CW'(c[5]), CW'(c[6]), CW'(c[7])};
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_random(int n);
        longint c[8];
        int mode, kind;
        for (int i = 0; i < n; i++) begin
            mode = $urandom_range(3);
            for (int k = 0; k < 8; k++)
                c[k] = rand_coord(mode);
            kind = $urandom_range(19);
            // occasional degenerate shapes: repeated corner or collinear
            if (kind == 0)
                begin c[2] = c[0]; c[3] = c[1]; end
            else if (kind == 1)
                begin c[4] = c[2] + (c[2] - c[0]) / 2; c[5] = c[3] + (c[3] - c[1]) / 2; end
            else if (kind == 2)
                begin c[6] = c[4]; c[7] = c[5]; end
            send_cell($urandom_range(1), c);
        end
    endtask

    initial begin
        longint c[8];
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed cells
        c = '{0, 0, 65536, 0, 0, 65536, 0, 0};
        send_cell(0, c);
        c = '{0, 0, 0, 65536, 65536, 0, 0, 0};
        send_cell(0, c);
        c = '{0, 0, 65536, 0, 65536, 65536, 0, 65536};
        send_cell(1, c);
        c = '{0, 0, 0, 65536, 65536, 65536, 65536, 0};
        send_cell(1, c);
        c = '{CMIN, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX};
        send_cell(1, c);
        c = '{CMAX, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX, CMIN};
        send_cell(1, c);
        c = '{CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, 0, 0};
        send_cell(0, c);
        c = '{0, 0, 1, 0, 0, 1, -1, -1};
        send_cell(1, c);
        // zero length edge
        c = '{5, 5, 5, 5, 100, 7, 0, 0};
        send_cell(0, c);
        // collinear triangle
        c = '{0, 0, 10, 10, 20, 20, 0, 0};
        send_cell(0, c);
        // second half degenerate
        c = '{0, 0, 10, 0, 10, 10, 20, 20};
        send_cell(1, c);
        // non-convex quad
        c = '{0, 0, 100, 0, 10, 10, 0, 100};
        send_cell(1, c);
        // triangle with a wild unused corner
        c = '{0, 0, 3, 0, 0, 7, CMIN, CMAX};
        send_cell(0, c);
        c = '{CMAX, 0, 0, CMAX, CMIN, 0, 0, CMIN};
        send_cell(1, c);
        c = '{-1, -1, 0, -1, -1, 0, 0, 0};
        send_cell(0, c);

        send_random(400);
        send_idle_pct = 84;
        send_random(250);
        send_idle_pct = 0;
        recv_stall_pct = 84;
        send_random(250);
        send_idle_pct = 13;
        recv_stall_pct = 13;
        send_random(300);
        in_valid <= 1'b0;
        recv_stall_pct = 0;

        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
